// File: sv/pnpc_pkg.sv
// ----------------------------------------------------------------------------
// pnpc_pkg: shared types and constants
// Payload structs, register indexes, scan and divider state codes.
// ----------------------------------------------------------------------------
package pnpc_pkg;

  localparam int unsigned WALL_ENTRIES_DEF = 1024;
  localparam int unsigned MAX_HEADS_DEF    = 1048576;

  localparam logic [1:0] REG_BOX_X = 2'd0;
  localparam logic [1:0] REG_BOX_Y = 2'd1;
  localparam logic [1:0] REG_BOX_Z = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  localparam logic [49:0] START_BEST = 50'd20000 << 20;
  localparam logic [49:0] FAR_LIMIT  = 50'd4 << 20;

  typedef struct packed {
    logic               cmd;
    logic [9:0]         entry_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] curvature_in;
    logic               frame_last;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         nearest_index;
    logic signed [15:0] curvature_out;
    logic               far_flag;
    logic               frame_done;
    logic signed [15:0] mean_curvature;
    logic [30:0]        curvature_variance;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_CURV, ST_DIV, ST_VAR, ST_OUT
  } state_t;

  // Squared minimum-image distance along one axis.
  function automatic logic [47:0] axis_sq(input logic signed [23:0] h,
                                          input logic signed [23:0] w,
                                          input logic [21:0] box);
    logic signed [25:0] d;
    logic [25:0] a;
    logic [24:0] m;
    begin
      d = 26'(h) - 26'(w);
      a = d[25] ? 26'(-d) : d;
      if ({a, 1'b0} > 27'(box)) begin
        if (d[25]) d = d + 26'(box);
        else d = d - 26'(box);
      end
      a = d[25] ? 26'(-d) : d;
      m = a[24:0];
      axis_sq = 48'(m) * 48'(m);
    end
  endfunction

endpackage

// File: sv/pnpc_ram.sv
// ----------------------------------------------------------------------------
// pnpc_ram: generic single-port-write RAM
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module pnpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/pnpc_cell.sv
// ----------------------------------------------------------------------------
// pnpc_cell: distance pipeline cell
// Compute one axis term, add the partial sum and pass it to the next cell.
// ----------------------------------------------------------------------------
module pnpc_cell
  import pnpc_pkg::*;
(
  input  logic               clk,
  input  logic signed [23:0] head,
  input  logic signed [23:0] wall,
  input  logic [21:0]        box,
  input  logic [49:0]        sum_in,
  output logic [49:0]        sum_r
);
  logic [49:0] sum_nxt;
  assign sum_nxt = sum_in + 50'(axis_sq(head, wall, box));
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end
endmodule

// File: sv/periodic_nearest_point_curvature_core.sv
// ----------------------------------------------------------------------------
// periodic_nearest_point_curvature_core: periodic nearest wall point search
// Wall table, minimum-image nearest search, curvature frame statistics.
// ----------------------------------------------------------------------------
// A load transaction writes one wall entry. A query transaction
// streams entries 0 .. N-1, N = min(wall_count, WALL_ENTRIES), from the wall
// RAMs, one per cycle, through a chain of three distance cells (x, y, z), each
// adding its axis term to the sum handed along from its neighbor; the last
// cell feeds a running minimum. A frame_last query then adds the restoring
// divides (sum and square sum, one bit a cycle) and the variance step. The
// input stalls from the accepted query until its result is loaded into the
// output register. The result sits in that register; while it waits, loads
// and the next query still go in, and only a query that reaches its result
// stage holds there until the register is free.
// ----------------------------------------------------------------------------
module periodic_nearest_point_curvature_core
  import pnpc_pkg::*;
#(
  parameter int unsigned WALL_ENTRIES = WALL_ENTRIES_DEF,
  parameter int unsigned MAX_HEADS    = MAX_HEADS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  localparam int unsigned AW = (WALL_ENTRIES > 1) ? $clog2(WALL_ENTRIES) : 1;
  localparam int unsigned DEP = (WALL_ENTRIES > 1) ? WALL_ENTRIES : 2;
  localparam int unsigned CW = $clog2(WALL_ENTRIES + 1);
  localparam int unsigned HW = $clog2(MAX_HEADS + 1);
  localparam logic [CW-1:0] WE_C = CW'(WALL_ENTRIES);
  localparam logic [HW-1:0] MH_C = HW'(MAX_HEADS);

  logic [21:0] box_x_r, box_y_r, box_z_r;
  logic [10:0] wall_count_r;

  state_t state_r, state_nxt;
  in_item_t q_r;
  logic [CW-1:0] n_r, rd_cnt_r;
  logic [CW-1:0] rd_cnt_nxt;
  logic [3:0] pipe_v_r;
  logic [AW-1:0] pidx_r [4];
  logic [49:0] best_r;
  logic [AW-1:0] best_i_r;
  logic signed [35:0] sum_r;
  logic [50:0] sq_r;
  logic [HW-1:0] cnt_r;
  logic signed [15:0] c_r;
  logic [50:0] num_r, rem_r;
  logic [35:0] snum_r, srem_r;
  logic [5:0] bit_r;
  logic neg_r;
  logic signed [15:0] mean_r;
  logic [31:0] msq_r;
  logic out_valid_r;
  out_item_t out_r;

  logic accept, wr, out_load;
  logic [AW-1:0] raddr;
  logic signed [23:0] wx, wy, wz;
  logic signed [15:0] wc;
  logic [49:0] s1, s2, s3;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  // Load the output register when the result stage finds it free or draining.
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign wr = accept && !in_data.cmd &&
              ({7'd0, in_data.entry_index} < 17'(WALL_ENTRIES));
  assign raddr = (state_r == ST_CURV || state_r == ST_DRAIN) ? best_i_r : rd_cnt_r[AW-1:0];

  pnpc_ram #(.WIDTH(24), .DEPTH(DEP)) u_rx (.clk, .we(wr), .waddr(in_data.entry_index[AW-1:0]),
    .wdata(in_data.pos_x), .raddr, .rdata(wx));
  pnpc_ram #(.WIDTH(24), .DEPTH(DEP)) u_ry (.clk, .we(wr), .waddr(in_data.entry_index[AW-1:0]),
    .wdata(in_data.pos_y), .raddr, .rdata(wy));
  pnpc_ram #(.WIDTH(24), .DEPTH(DEP)) u_rz (.clk, .we(wr), .waddr(in_data.entry_index[AW-1:0]),
    .wdata(in_data.pos_z), .raddr, .rdata(wz));
  pnpc_ram #(.WIDTH(16), .DEPTH(DEP)) u_rc (.clk, .we(wr), .waddr(in_data.entry_index[AW-1:0]),
    .wdata(in_data.curvature_in), .raddr, .rdata(wc));

  // Chain of axis cells; the y and z wall words are delayed to line up.
  logic signed [23:0] wy_d_r, wz_d_r, wz_dd_r;
  always_ff @(posedge clk) begin
    wy_d_r <= wy;
    wz_d_r <= wz;
    wz_dd_r <= wz_d_r;
  end
  pnpc_cell u_cx (.clk, .head(q_r.pos_x), .wall(wx), .box(box_x_r), .sum_in(50'd0), .sum_r(s1));
  pnpc_cell u_cy (.clk, .head(q_r.pos_y), .wall(wy_d_r), .box(box_y_r), .sum_in(s1), .sum_r(s2));
  pnpc_cell u_cz (.clk, .head(q_r.pos_z), .wall(wz_dd_r), .box(box_z_r), .sum_in(s2),
    .sum_r(s3));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= 22'h3FFFFF;
      box_y_r <= 22'h3FFFFF;
      box_z_r <= 22'h3FFFFF;
      wall_count_r <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_X: box_x_r <= cfg_data;
        REG_BOX_Y: box_y_r <= cfg_data;
        REG_BOX_Z: box_z_r <= cfg_data;
        REG_COUNT: wall_count_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_cnt_nxt = rd_cnt_r;
    unique case (state_r)
      ST_IDLE: if (accept && in_data.cmd) begin
        state_nxt = ST_SCAN;
        rd_cnt_nxt = '0;
      end
      ST_SCAN: begin
        if (rd_cnt_r >= n_r) state_nxt = ST_DRAIN;
        else rd_cnt_nxt = rd_cnt_r + 1'b1;
      end
      ST_DRAIN: if (pipe_v_r == 4'd0) state_nxt = ST_CURV;
      ST_CURV: state_nxt = q_r.frame_last ? ST_DIV : ST_OUT;
      ST_DIV: if (bit_r == 6'd0) state_nxt = ST_VAR;
      ST_VAR: state_nxt = ST_OUT;
      ST_OUT: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [CW-1:0] wc_clip;
  assign wc_clip = ({6'd0, wall_count_r} > 17'(WALL_ENTRIES)) ? WE_C : CW'(wall_count_r);

  // Divide step helpers
  logic [51:0] rem_sh;
  logic [36:0] srem_sh;
  assign rem_sh  = {rem_r, num_r[50]};
  assign srem_sh = {srem_r, snum_r[35]};
  logic [31:0] q2;
  assign q2 = num_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_cnt_r <= '0;
      pipe_v_r <= 4'd0;
      out_valid_r <= 1'b0;
      sum_r <= '0;
      sq_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      // advance the index shadow of the cell chain
      pipe_v_r <= {pipe_v_r[2:0], (state_r == ST_SCAN) && (rd_cnt_r < n_r)};
      pidx_r[0] <= rd_cnt_r[AW-1:0];
      for (int k = 1; k < 4; k++) pidx_r[k] <= pidx_r[k-1];
      if (pipe_v_r[3] && s3 < best_r) begin
        best_r <= s3;
        best_i_r <= pidx_r[3];
      end
      unique case (state_r)
        ST_IDLE: if (accept && in_data.cmd) begin
          q_r <= in_data;
          n_r <= wc_clip;
          best_r <= START_BEST;
          best_i_r <= '0;
        end
        ST_CURV: begin
          logic signed [35:0] ns;
          logic [50:0] nq;
          logic [HW-1:0] nc;
          ns = sum_r; nq = sq_r; nc = cnt_r;
          c_r <= wc;
          if (cnt_r < MH_C) begin
            ns = sum_r + 36'(wc);
            nq = sq_r + 51'(32'(wc) * 32'(wc));
            nc = cnt_r + 1'b1;
          end
          sum_r <= ns; sq_r <= nq; cnt_r <= nc;
          num_r <= nq; rem_r <= '0;
          neg_r <= ns[35];
          snum_r <= ns[35] ? 36'(-ns) : ns;
          srem_r <= '0;
          bit_r <= 6'd50;
        end
        ST_DIV: begin
          // one quotient bit per cycle for both divides
          if (cnt_r != '0 && rem_sh >= 52'(cnt_r)) begin
            rem_r <= 51'(rem_sh - 52'(cnt_r)); num_r <= {num_r[49:0], 1'b1};
          end else begin
            rem_r <= rem_sh[50:0]; num_r <= {num_r[49:0], 1'b0};
          end
          if (bit_r <= 6'd35) begin
            if (cnt_r != '0 && srem_sh >= 37'(cnt_r)) begin
              srem_r <= 36'(srem_sh - 37'(cnt_r)); snum_r <= {snum_r[34:0], 1'b1};
            end else begin
              srem_r <= srem_sh[35:0]; snum_r <= {snum_r[34:0], 1'b0};
            end
          end
          bit_r <= bit_r - 1'b1;
        end
        ST_VAR: begin
          logic signed [15:0] m;
          m = neg_r ? 16'(-snum_r[15:0]) : snum_r[15:0];
          if (cnt_r == '0) m = '0;
          mean_r <= m;
          msq_r <= 32'(m) * 32'(m);
          if (cnt_r == '0) num_r <= '0;
        end
        ST_OUT: if (out_load) begin
          out_r.nearest_index <= 10'(best_i_r);
          out_r.curvature_out <= c_r;
          out_r.far_flag <= best_r > FAR_LIMIT;
          out_r.frame_done <= q_r.frame_last;
          out_r.mean_curvature <= q_r.frame_last ? mean_r : 16'd0;
          out_r.curvature_variance <= (q_r.frame_last && q2 > msq_r) ?
                                      31'(q2 - msq_r) : 31'd0;
          if (q_r.frame_last) begin
            sum_r <= '0; sq_r <= '0; cnt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
